FILE: rtl/mbm_pkg.sv
package mbm_pkg;

    // Bus action codes.
    localparam logic [1:0] ACT_MEM_READ  = 2'd0;
    localparam logic [1:0] ACT_MEM_WRITE = 2'd1;
    localparam logic [1:0] ACT_IO_WRITE  = 2'd2;

    // Region codes.
    localparam logic [2:0] REG_UNMAPPED = 3'd0;
    localparam logic [2:0] REG_IPL      = 3'd1;
    localparam logic [2:0] REG_BASIC    = 3'd2;
    localparam logic [2:0] REG_EXT      = 3'd3;
    localparam logic [2:0] REG_RAM      = 3'd4;
    localparam logic [2:0] REG_COMMON   = 3'd5;

    // System modes.
    localparam logic [1:0] MODE_IPL   = 2'd0;
    localparam logic [1:0] MODE_FLAT  = 2'd1;
    localparam logic [1:0] MODE_ROM   = 2'd2;
    localparam logic [1:0] MODE_RAM   = 2'd3;

    // I/O ports that load the banking registers.
    localparam logic [7:0] PORT_MODE = 8'hFD;
    localparam logic [7:0] PORT_PAGE = 8'hFE;

    localparam int OFFSET_W = 18;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_word;

    typedef struct packed {
        logic [2:0]          region;
        logic [OFFSET_W-1:0] offset;
        logic                write_enable;
        logic [7:0]          write_byte;
    } t_out_word;

    typedef struct packed {
        logic [1:0] system_mode;
        logic [2:0] rom_page;
        logic [3:0] ram_page;
    } t_bank_state;

endpackage

FILE: rtl/mbm_map.sv
module mbm_map (
    input  logic [15:0]                   i_address,
    input  mbm_pkg::t_bank_state          i_bank,
    output logic [2:0]                    o_region,
    output logic [mbm_pkg::OFFSET_W-1:0]  o_offset
);

    logic [mbm_pkg::OFFSET_W-1:0] a_ext;
    logic [1:0]                   rom_hi;
    logic [3:0]                   ram_hi;

    assign a_ext  = {2'b00, i_address};
    // Extension ROM uses page minus three, BASIC uses page plus one, as the
    // 8 KB block number within the region.
    assign rom_hi = (i_bank.rom_page >= 3'd3) ? 2'(i_bank.rom_page - 3'd3)
                                              : 2'(i_bank.rom_page + 3'd1);
    // Pages 2..13 start at 64 KB, one 16 KB block per page.
    assign ram_hi = i_bank.ram_page + 4'd2;

    always_comb begin
        o_region = mbm_pkg::REG_UNMAPPED;
        o_offset = '0;
        if (i_bank.system_mode == mbm_pkg::MODE_FLAT) begin
            if (i_address < 16'hF800) begin
                o_region = mbm_pkg::REG_RAM;
                o_offset = a_ext;
            end else begin
                o_region = mbm_pkg::REG_COMMON;
                o_offset = {7'd0, i_address[10:0]};
            end
        end else if (i_address[15:14] == 2'b11) begin
            // Upper 16 KB window follows the RAM page.
            case (i_bank.ram_page)
                4'd0: begin
                    o_region = mbm_pkg::REG_RAM;
                    o_offset = a_ext;
                end
                4'd1: begin
                    o_region = mbm_pkg::REG_RAM;
                    o_offset = {4'd0, i_address[13:0]};
                end
                4'd14: begin
                    o_region = mbm_pkg::REG_UNMAPPED;
                end
                4'd15: begin
                    if (i_address[15:11] == 5'b11111) begin
                        o_region = mbm_pkg::REG_COMMON;
                        o_offset = {7'd0, i_address[10:0]};
                    end
                end
                default: begin
                    o_region = mbm_pkg::REG_RAM;
                    o_offset = {ram_hi, i_address[13:0]};
                end
            endcase
        end else if (i_address[15:14] != 2'b00) begin
            o_region = mbm_pkg::REG_RAM;
            o_offset = a_ext;
        end else if (i_bank.system_mode == mbm_pkg::MODE_IPL) begin
            if (i_address[13:12] == 2'b00) begin
                o_region = mbm_pkg::REG_IPL;
                o_offset = {5'd0, 1'b1, i_address[11:0]};
            end else if (i_address[13]) begin
                o_region = mbm_pkg::REG_BASIC;
                o_offset = a_ext;
            end
        end else if (!i_address[13]) begin
            o_region = (i_bank.system_mode == mbm_pkg::MODE_ROM) ? mbm_pkg::REG_BASIC
                                                                 : mbm_pkg::REG_RAM;
            o_offset = a_ext;
        end else if (i_bank.rom_page == 3'd7) begin
            o_region = mbm_pkg::REG_UNMAPPED;
        end else if (i_bank.rom_page >= 3'd3) begin
            o_region = mbm_pkg::REG_EXT;
            o_offset = {3'd0, rom_hi, i_address[12:0]};
        end else if (i_bank.system_mode == mbm_pkg::MODE_ROM) begin
            o_region = mbm_pkg::REG_BASIC;
            o_offset = {3'd0, rom_hi, i_address[12:0]};
        end else begin
            o_region = mbm_pkg::REG_RAM;
            case (i_bank.rom_page)
                3'd1:    o_offset = {2'd0, 3'b110, i_address[12:0]};
                3'd2:    o_offset = {2'd0, 3'b111, i_address[12:0]};
                default: o_offset = a_ext;
            endcase
        end
    end

endmodule

FILE: rtl/memory_bank_mapper.sv
// Memory bank mapper: translates CPU bus actions into a target region and a
// byte offset within it, and keeps the mode and page registers for banking.
// The input channel (i_in_valid, o_in_stall, i_in_word) takes one word per
// bus action: a memory read, a memory write or an I/O port write. The output
// channel (o_out_valid, i_out_stall, o_out_word) returns exactly one word
// for every input word, in order.
// A word accepted is held in the input register, decoded, and lands in the
// output register once that is free or being taken. Throughput is one word
// per cycle while the receiver does not stall; the only logic between the two
// registers is the address decode in mbm_map and a few compares.
// An I/O write to port 0xFD or 0xFE changes the banking registers as it
// moves into the output register, so the very next word sees the new map.
// Reset clears both valid flags and sets mode and pages to zero.
// When the receiver stalls, the output word holds; the input register can
// still take one more word, and o_in_stall rises only once both are full.
module memory_bank_mapper (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  mbm_pkg::t_in_word      i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output mbm_pkg::t_out_word     o_out_word
);

    // Input register.
    logic                 r_in_valid;
    mbm_pkg::t_in_word    r_in;

    // Output register.
    logic                 r_out_valid;
    mbm_pkg::t_out_word   r_out;
    mbm_pkg::t_out_word   n_out;

    // Banking registers.
    mbm_pkg::t_bank_state r_bank;
    mbm_pkg::t_bank_state n_bank;

    logic                          advance;
    logic                          move;
    logic [2:0]                    map_region;
    logic [mbm_pkg::OFFSET_W-1:0]  map_offset;

    // The pipeline moves whenever the output register is free or being taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign move       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    mbm_map u_map (
        .i_address (r_in.address),
        .i_bank    (r_bank),
        .o_region  (map_region),
        .o_offset  (map_offset)
    );

    // Result of the word in the input register, and its effect on banking.
    always_comb begin
        n_out  = '0;
        n_bank = r_bank;
        case (r_in.action)
            mbm_pkg::ACT_MEM_READ: begin
                n_out.region = map_region;
                n_out.offset = map_offset;
            end
            mbm_pkg::ACT_MEM_WRITE: begin
                // Only RAM and common RAM take writes; anything else is dropped.
                if (map_region == mbm_pkg::REG_RAM || map_region == mbm_pkg::REG_COMMON) begin
                    n_out.region       = map_region;
                    n_out.offset       = map_offset;
                    n_out.write_enable = 1'b1;
                    n_out.write_byte   = r_in.data;
                end
            end
            mbm_pkg::ACT_IO_WRITE: begin
                if (r_in.address[7:0] == mbm_pkg::PORT_MODE) begin
                    n_bank.system_mode = r_in.data[1:0];
                end else if (r_in.address[7:0] == mbm_pkg::PORT_PAGE) begin
                    n_bank.rom_page = r_in.data[2:0];
                    n_bank.ram_page = r_in.data[7:4];
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bank      <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (move) begin
                r_bank <= n_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
